FILE: design/assert_macros.svh
// Assertion helpers used by the finger kinematics core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/ffk_pkg.sv
package ffk_pkg;

  localparam int ANG_W = 16;
  localparam int LEN_W = 16;
  localparam int ROT_W = 16;
  localparam int POS_W = 24;
  localparam int SEL_W = 2;
  localparam int IDX_W = 3;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_TRIG_FRAC_BITS = 14;

  // Angle widths: full range before reduction, residual during rotation.
  localparam int AW = 36;
  localparam int ZW = 33;
  localparam int XW = 34;

  localparam logic signed [AW-1:0] Q30_PI = 36'sd3373259426;
  localparam logic signed [AW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [AW-1:0] Q30_TWO_PI = 36'sd6746518852;
  localparam logic signed [XW-1:0] Q30_GAIN = 34'sd652032874;

  localparam logic [IDX_W-1:0] REG_PALM_OFFSET = 3'd0;
  localparam logic [IDX_W-1:0] REG_FIRST_LINK = 3'd1;
  localparam logic [IDX_W-1:0] REG_SECOND_LINK = 3'd2;
  localparam logic [IDX_W-1:0] REG_THIRD_LINK = 3'd3;
  localparam logic [IDX_W-1:0] REG_TIP_OFFSET = 3'd4;

  localparam logic [SEL_W-1:0] FINGER_NEG = 2'd0;
  localparam logic [SEL_W-1:0] FINGER_POS = 2'd1;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 33'sd843314857;
      1: v = 33'sd497837829;
      2: v = 33'sd263043837;
      3: v = 33'sd133525159;
      4: v = 33'sd67021687;
      5: v = 33'sd33543516;
      6: v = 33'sd16775851;
      7: v = 33'sd8388437;
      8: v = 33'sd4194283;
      9: v = 33'sd2097149;
      10: v = 33'sd1048576;
      11: v = 33'sd524288;
      12: v = 33'sd262144;
      13: v = 33'sd131072;
      14: v = 33'sd65536;
      15: v = 33'sd32768;
      16: v = 33'sd16384;
      17: v = 33'sd8192;
      18: v = 33'sd4096;
      19: v = 33'sd2048;
      20: v = 33'sd1024;
      21: v = 33'sd512;
      22: v = 33'sd256;
      23: v = 33'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/finger_forward_kinematics_core.sv
// Forward kinematics of one three-joint finger.
// Input: pulse start with finger_sel and the spread, inner and outer joint
// angles (Q2.13 radians); a request is taken at any edge where start is high
// and busy is low. busy is always low: a new request may enter every cycle.
// Output: done is high for one cycle with the rotation entries (Q1.14) and
// the saturated position (1/256 mm). Results leave in request order.
// From the accepting edge to the edge ending the done cycle a request passes
// input, range reduction and quadrant fold stages, one stage per CORDIC
// iteration, a rounding stage, then four multiply and sum stages. Throughput
// is one request per cycle, set by the CORDIC pipe.
// Link lengths are written through cfg_valid/cfg_index/cfg_data; cfg_ready
// is always high, and writes to unknown indexes are dropped. Registers must
// only change while no request is in flight.
// Reset loads the default link lengths and empties the pipeline. The
// receiver cannot stall: every result is shown for exactly one cycle.
`include "assert_macros.svh"
module finger_forward_kinematics_core #(
  parameter int CORDIC_STAGES = ffk_pkg::DEF_CORDIC_STAGES,
  parameter int TRIG_FRAC_BITS = ffk_pkg::DEF_TRIG_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [ffk_pkg::SEL_W-1:0]          finger_sel,
  input  logic signed [ffk_pkg::ANG_W-1:0]   spread_angle,
  input  logic signed [ffk_pkg::ANG_W-1:0]   inner_angle,
  input  logic signed [ffk_pkg::ANG_W-1:0]   outer_angle,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ffk_pkg::IDX_W-1:0]          cfg_index,
  input  logic [ffk_pkg::LEN_W-1:0]          cfg_data,
  output logic                               done,
  output logic signed [ffk_pkg::ROT_W-1:0]   rot_xx,
  output logic signed [ffk_pkg::ROT_W-1:0]   rot_xy,
  output logic signed [ffk_pkg::ROT_W-1:0]   rot_xz,
  output logic signed [ffk_pkg::POS_W-1:0]   pos_x,
  output logic signed [ffk_pkg::ROT_W-1:0]   rot_yx,
  output logic signed [ffk_pkg::ROT_W-1:0]   rot_yy,
  output logic signed [ffk_pkg::ROT_W-1:0]   rot_yz,
  output logic signed [ffk_pkg::POS_W-1:0]   pos_y,
  output logic signed [ffk_pkg::ROT_W-1:0]   rot_zx,
  output logic signed [ffk_pkg::ROT_W-1:0]   rot_zz,
  output logic signed [ffk_pkg::POS_W-1:0]   pos_z
);
  import ffk_pkg::*;

  localparam int F = TRIG_FRAC_BITS;
  localparam int N = CORDIC_STAGES;
  localparam int TW = F + 2;
  localparam int SHR = 30 - F;
  localparam logic signed [XW-1:0] XRND = XW'(64'sd1 <<< (SHR - 1));
  localparam logic signed [XW-1:0] TRIG_ONE = XW'(64'sd1 <<< F);
  localparam int PRW = 2 * TW;
  localparam int PSH = 2 * F - 14;
  localparam logic signed [PRW-1:0] PRND = PRW'(64'sd1 <<< (PSH - 1));
  localparam int LSH = (F < 14) ? 14 - F : 0;
  localparam int RSH = (F > 14) ? F - 14 : 0;
  localparam logic signed [31:0] RND32 = (RSH > 0) ? (32'sd1 <<< (RSH - 1)) : 32'sd0;
  localparam int LPW = TW + 17;
  localparam int RW = TW + 20;
  localparam int PZW = TW + 19;
  localparam int HW = RW - 16;
  localparam int PW = 2 * TW + 21;
  localparam logic signed [PW-1:0] POS_RND = PW'(64'sd1 <<< (2 * F - 1));
  localparam logic signed [PW-1:0] PMAX = PW'(64'sd8388607);
  localparam logic signed [PW-1:0] PMIN = PW'(-64'sd8388608);
  localparam int LAT = N + 8;

  // Configuration registers.
  logic [LEN_W-1:0] palm_offset, first_link, second_link, third_link, tip_offset;

  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      palm_offset <= 16'd6400;
      first_link <= 16'd12800;
      second_link <= 16'd17920;
      third_link <= 16'd12800;
      tip_offset <= 16'd2432;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PALM_OFFSET: palm_offset <= cfg_data;
        REG_FIRST_LINK: first_link <= cfg_data;
        REG_SECOND_LINK: second_link <= cfg_data;
        REG_THIRD_LINK: third_link <= cfg_data;
        REG_TIP_OFFSET: tip_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 0: angles widened to Q30. Lane 0 is the base, 1 inner, 2 inner+outer.
  logic v0;
  logic [SEL_W-1:0] f0;
  logic signed [AW-1:0] a0 [0:2];
  logic signed [AW-1:0] sp_w, base_term;

  always_comb begin
    sp_w = AW'(spread_angle) <<< 17;
    case (finger_sel)
      FINGER_NEG: base_term = -sp_w + Q30_HALF_PI - Q30_HALF_PI - Q30_HALF_PI;
      FINGER_POS: base_term = sp_w - Q30_HALF_PI;
      default: base_term = Q30_HALF_PI;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    f0 <= finger_sel;
    a0[0] <= base_term;
    a0[1] <= AW'(inner_angle) <<< 17;
    a0[2] <= (AW'(inner_angle) + AW'(outer_angle)) <<< 17;
  end

  // Stage 1: one whole turn is always enough to land in [-pi, pi].
  logic v1;
  logic [SEL_W-1:0] f1;
  logic signed [AW-1:0] a1 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    f1 <= f0;
    for (int l = 0; l < 3; l++) begin
      if (a0[l] > Q30_PI) begin
        a1[l] <= a0[l] - Q30_TWO_PI;
      end else if (a0[l] < -Q30_PI) begin
        a1[l] <= a0[l] + Q30_TWO_PI;
      end else begin
        a1[l] <= a0[l];
      end
    end
  end

  // Stage 2: fold into [-pi/2, pi/2] and start the rotation.
  logic cv [0:N];
  logic [SEL_W-1:0] cf [0:N];
  logic [2:0] cneg [0:N];
  logic signed [XW-1:0] cx [0:N][0:2];
  logic signed [XW-1:0] cy [0:N][0:2];
  logic signed [ZW-1:0] cz [0:N][0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= v1;
    end
    cf[0] <= f1;
    for (int l = 0; l < 3; l++) begin
      cx[0][l] <= Q30_GAIN;
      cy[0][l] <= '0;
      if (a1[l] > Q30_HALF_PI) begin
        cz[0][l] <= ZW'(a1[l] - Q30_PI);
        cneg[0][l] <= 1'b1;
      end else if (a1[l] < -Q30_HALF_PI) begin
        cz[0][l] <= ZW'(a1[l] + Q30_PI);
        cneg[0][l] <= 1'b1;
      end else begin
        cz[0][l] <= ZW'(a1[l]);
        cneg[0][l] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
      cf[i+1] <= cf[i];
      cneg[i+1] <= cneg[i];
      for (int l = 0; l < 3; l++) begin
        // A zero residual rotates in the positive direction.
        if (!cz[i][l][ZW-1]) begin
          cx[i+1][l] <= cx[i][l] - (cy[i][l] >>> i);
          cy[i+1][l] <= cy[i][l] + (cx[i][l] >>> i);
          cz[i+1][l] <= cz[i][l] - atan_q30(i);
        end else begin
          cx[i+1][l] <= cx[i][l] + (cy[i][l] >>> i);
          cy[i+1][l] <= cy[i][l] - (cx[i][l] >>> i);
          cz[i+1][l] <= cz[i][l] + atan_q30(i);
        end
      end
    end
  end

  function automatic logic signed [TW-1:0] trig_fix(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = (v + XRND) >>> SHR;
    if (r > TRIG_ONE) begin
      r = TRIG_ONE;
    end else if (r < -TRIG_ONE) begin
      r = -TRIG_ONE;
    end
    return r[TW-1:0];
  endfunction

  function automatic logic signed [ROT_W-1:0] trig_q14(input logic signed [TW-1:0] v);
    logic signed [31:0] e;
    e = 32'(v) <<< LSH;
    e = (e + RND32) >>> RSH;
    return e[ROT_W-1:0];
  endfunction

  function automatic logic signed [ROT_W-1:0] prod_q14(input logic signed [PRW-1:0] v);
    logic signed [PRW-1:0] e;
    e = (v + PRND) >>> PSH;
    return e[ROT_W-1:0];
  endfunction

  // Trig stage: undo the fold, round and clamp to +-1.
  logic vt;
  logic [SEL_W-1:0] ft;
  logic signed [TW-1:0] st [0:2];
  logic signed [TW-1:0] ct [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else begin
      vt <= cv[N];
    end
    ft <= cf[N];
    for (int l = 0; l < 3; l++) begin
      ct[l] <= trig_fix(cneg[N][l] ? -cx[N][l] : cx[N][l]);
      st[l] <= trig_fix(cneg[N][l] ? -cy[N][l] : cy[N][l]);
    end
  end

  // P1: trig products and link-length products.
  logic vp1;
  logic [SEL_W-1:0] fp1;
  logic signed [TW-1:0] c1_p1, s1_p1, c23_p1, s23_p1;
  logic signed [PRW-1:0] p_c1c23, p_nc1s23, p_s1c23, p_ns1s23;
  logic signed [LPW-1:0] m_a3c23, m_d3s23, m_a2c2, m_a3s23, m_d3c23, m_a2s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
    end else begin
      vp1 <= vt;
    end
    fp1 <= ft;
    c1_p1 <= ct[0];
    s1_p1 <= st[0];
    c23_p1 <= ct[2];
    s23_p1 <= st[2];
    p_c1c23 <= PRW'(ct[0]) * PRW'(ct[2]);
    p_nc1s23 <= -(PRW'(ct[0]) * PRW'(st[2]));
    p_s1c23 <= PRW'(st[0]) * PRW'(ct[2]);
    p_ns1s23 <= -(PRW'(st[0]) * PRW'(st[2]));
    m_a3c23 <= LPW'($signed({1'b0, third_link})) * LPW'(ct[2]);
    m_d3s23 <= LPW'($signed({1'b0, tip_offset})) * LPW'(st[2]);
    m_a2c2 <= LPW'($signed({1'b0, second_link})) * LPW'(ct[1]);
    m_a3s23 <= LPW'($signed({1'b0, third_link})) * LPW'(st[2]);
    m_d3c23 <= LPW'($signed({1'b0, tip_offset})) * LPW'(ct[2]);
    m_a2s2 <= LPW'($signed({1'b0, second_link})) * LPW'(st[1]);
  end

  // P2: radial reach in the finger plane, z sum and rounded rotation entries.
  logic vp2;
  logic [SEL_W-1:0] fp2;
  logic signed [TW-1:0] c1_p2, s1_p2;
  logic signed [RW-1:0] reach;
  logic signed [PZW-1:0] zsum_p2;
  logic signed [ROT_W-1:0] xx2, xy2, xz2, yx2, yy2, yz2, zx2, zz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp2 <= 1'b0;
    end else begin
      vp2 <= vp1;
    end
    fp2 <= fp1;
    c1_p2 <= c1_p1;
    s1_p2 <= s1_p1;
    reach <= RW'(m_a3c23) - RW'(m_d3s23) + RW'(m_a2c2)
           + (RW'($signed({1'b0, first_link})) <<< F);
    zsum_p2 <= PZW'(m_a3s23) + PZW'(m_d3c23) + PZW'(m_a2s2);
    xx2 <= prod_q14(p_c1c23);
    xz2 <= prod_q14(p_nc1s23);
    yx2 <= prod_q14(p_s1c23);
    yz2 <= prod_q14(p_ns1s23);
    xy2 <= trig_q14(-s1_p1);
    yy2 <= trig_q14(c1_p1);
    zx2 <= trig_q14(s23_p1);
    zz2 <= trig_q14(c23_p1);
  end

  // P3: reach times c1 and s1, split into high and low partial products.
  logic vp3;
  logic [SEL_W-1:0] fp3;
  logic signed [TW+16:0] pcl, psl;
  logic signed [TW+HW-1:0] pch, psh;
  logic signed [PZW-1:0] zsum_p3;
  logic signed [ROT_W-1:0] xx3, xy3, xz3, yx3, yy3, yz3, zx3, zz3;
  logic signed [16:0] reach_lo;
  logic signed [HW-1:0] reach_hi;

  assign reach_lo = $signed({1'b0, reach[15:0]});
  assign reach_hi = reach[RW-1:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp3 <= 1'b0;
    end else begin
      vp3 <= vp2;
    end
    fp3 <= fp2;
    pcl <= (TW+17)'(c1_p2) * (TW+17)'(reach_lo);
    psl <= (TW+17)'(s1_p2) * (TW+17)'(reach_lo);
    pch <= (TW+HW)'(c1_p2) * (TW+HW)'(reach_hi);
    psh <= (TW+HW)'(s1_p2) * (TW+HW)'(reach_hi);
    zsum_p3 <= zsum_p2;
    xx3 <= xx2;
    xy3 <= xy2;
    xz3 <= xz2;
    yx3 <= yx2;
    yy3 <= yy2;
    yz3 <= yz2;
    zx3 <= zx2;
    zz3 <= zz2;
  end

  function automatic logic signed [POS_W-1:0] pos_fix(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v + POS_RND) >>> (2 * F);
    if (r > PMAX) begin
      r = PMAX;
    end else if (r < PMIN) begin
      r = PMIN;
    end
    return r[POS_W-1:0];
  endfunction

  // P4: final sums, rounding, saturation and the output register.
  logic signed [PW-1:0] palm_term, px_full, py_full, pz_full;

  always_comb begin
    case (fp3)
      FINGER_NEG: palm_term = -(PW'($signed({1'b0, palm_offset})) <<< (2 * F));
      FINGER_POS: palm_term = PW'($signed({1'b0, palm_offset})) <<< (2 * F);
      default: palm_term = '0;
    endcase
    px_full = (PW'(pch) <<< 16) + PW'(pcl) + palm_term;
    py_full = (PW'(psh) <<< 16) + PW'(psl);
    pz_full = PW'(zsum_p3) <<< F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vp3;
    end
    pos_x <= pos_fix(px_full);
    pos_y <= pos_fix(py_full);
    pos_z <= pos_fix(pz_full);
    rot_xx <= xx3;
    rot_xy <= xy3;
    rot_xz <= xz3;
    rot_yx <= yx3;
    rot_yy <= yy3;
    rot_yz <= yz3;
    rot_zx <= zx3;
    rot_zz <= zz3;
  end

  `ASSERT_PROP(a_latency, clk, rst, (start && !busy) |-> ##LAT done)
  `ASSERT_IMPL(a_zz_unit, clk, rst, done, (rot_zz <= 16'sd16384) && (rot_zz >= -16'sd16384))
  `ASSERT_IMPL(a_yy_unit, clk, rst, done, (rot_yy <= 16'sd16384) && (rot_yy >= -16'sd16384))
  `ASSERT_PROP(a_trig_unit, clk, rst, vt |-> (ct[2] <= TW'(TRIG_ONE)) && (ct[2] >= -TW'(TRIG_ONE)))

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ffk_pkg::*;

  localparam int STAGES = DEF_CORDIC_STAGES;
  localparam int FB = DEF_TRIG_FRAC_BITS;
  localparam int LATENCY = STAGES + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1000;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [ROT_W-1:0] rxx, rxy, rxz, ryx, ryy, ryz, rzx, rzz;
    logic signed [POS_W-1:0] px, py, pz;
  } pose_t;

  typedef struct {
    logic [SEL_W-1:0] sel;
    logic signed [ANG_W-1:0] spread, inner, outer;
    bit has_pose;
    pose_t pose;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [SEL_W-1:0] finger_sel = '0;
  logic signed [ANG_W-1:0] spread_angle = '0, inner_angle = '0, outer_angle = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic done;
  logic signed [ROT_W-1:0] rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz, rot_zx, rot_zz;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;

  finger_forward_kinematics_core uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Link lengths as the predictor sees them.
  longint link_len [5];
  pose_t pose_queue [$];
  int errors = 0;
  int idle_cycles = 0;

  longint atan_tab [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic void trig_eval(longint a, output longint s, output longint c);
    longint x, y, z, dx, dy, one;
    bit flip;
    x = 652032874; y = 0; one = longint'(1) << FB; flip = 0;
    while (a > 64'sd3373259426) a -= 64'sd6746518852;
    while (a < -64'sd3373259426) a += 64'sd6746518852;
    if (a > 64'sd1686629713) begin
      a -= 64'sd3373259426; flip = 1;
    end else if (a < -64'sd1686629713) begin
      a += 64'sd3373259426; flip = 1;
    end
    z = a;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    x = rnd_shift(x, 30 - FB);
    y = rnd_shift(y, 30 - FB);
    if (x > one) x = one;
    if (x < -one) x = -one;
    if (y > one) y = one;
    if (y < -one) y = -one;
    s = y; c = x;
  endfunction

  function automatic longint prod_q14(longint v);
    return rnd_shift(v, 2 * FB - 14);
  endfunction

  function automatic longint pos_sat(longint v);
    v = rnd_shift(v, 2 * FB);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  function automatic pose_t finger_pose(logic [SEL_W-1:0] sel,
      logic signed [ANG_W-1:0] spread, inner, outer);
    pose_t p;
    longint rs, js, t1, t2, t23, s1, c1, s2, c2, s23, c23, px, py, pz, sc;
    rs = (sel == FINGER_NEG) ? -1 : (sel == FINGER_POS) ? 1 : 0;
    js = (sel == FINGER_NEG || sel == FINGER_POS) ? 1 : -1;
    t1 = rs * longint'(spread) * 131072 - js * 1686629713;
    t2 = longint'(inner) * 131072;
    t23 = (longint'(inner) + longint'(outer)) * 131072;
    trig_eval(t1, s1, c1);
    trig_eval(t2, s2, c2);
    trig_eval(t23, s23, c23);
    sc = longint'(1) << FB;
    px = link_len[3] * c1 * c23 - link_len[4] * c1 * s23 + link_len[2] * c1 * c2
       + link_len[1] * c1 * sc + rs * link_len[0] * sc * sc;
    py = link_len[3] * s1 * c23 - link_len[4] * s1 * s23 + link_len[2] * s1 * c2
       + link_len[1] * s1 * sc;
    pz = (link_len[3] * s23 + link_len[4] * c23 + link_len[2] * s2) * sc;
    p.rxx = ROT_W'(prod_q14(c1 * c23));
    p.rxy = ROT_W'(rnd_shift(-s1, FB - 14));
    p.rxz = ROT_W'(prod_q14(-(c1 * s23)));
    p.px = POS_W'(pos_sat(px));
    p.ryx = ROT_W'(prod_q14(s1 * c23));
    p.ryy = ROT_W'(rnd_shift(c1, FB - 14));
    p.ryz = ROT_W'(prod_q14(-(s1 * s23)));
    p.py = POS_W'(pos_sat(py));
    p.rzx = ROT_W'(rnd_shift(s23, FB - 14));
    p.rzz = ROT_W'(rnd_shift(c23, FB - 14));
    p.pz = POS_W'(pos_sat(pz));
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result checker and stall watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
      if (done) begin
        if (pose_queue.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          pose_t w;
          w = pose_queue.pop_front();
          if (rot_xx !== w.rxx) report_mismatch("rot_xx", rot_xx, w.rxx);
          if (rot_xy !== w.rxy) report_mismatch("rot_xy", rot_xy, w.rxy);
          if (rot_xz !== w.rxz) report_mismatch("rot_xz", rot_xz, w.rxz);
          if (pos_x !== w.px) report_mismatch("pos_x", pos_x, w.px);
          if (rot_yx !== w.ryx) report_mismatch("rot_yx", rot_yx, w.ryx);
          if (rot_yy !== w.ryy) report_mismatch("rot_yy", rot_yy, w.ryy);
          if (rot_yz !== w.ryz) report_mismatch("rot_yz", rot_yz, w.ryz);
          if (pos_y !== w.py) report_mismatch("pos_y", pos_y, w.py);
          if (rot_zx !== w.rzx) report_mismatch("rot_zx", rot_zx, w.rzx);
          if (rot_zz !== w.rzz) report_mismatch("rot_zz", rot_zz, w.rzz);
          if (pos_z !== w.pz) report_mismatch("pos_z", pos_z, w.pz);
        end
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_TIP_OFFSET) link_len[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Issues one request; start stays high across back-to-back requests.
  task automatic send_request(logic [SEL_W-1:0] sel, logic signed [ANG_W-1:0] sp, inn,
      outr, bit has_pose, pose_t want, bit gaps);
    int gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15)) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    finger_sel <= sel;
    spread_angle <= sp;
    inner_angle <= inn;
    outer_angle <= outr;
    @(posedge clk);
    while (busy) @(posedge clk);
    pose_queue.push_back(has_pose ? want : finger_pose(sel, sp, inn, outr));
  endtask

  task automatic release_start;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic random_phase(int n);
    logic signed [ANG_W-1:0] a [3];
    pose_t nil;
    for (int k = 0; k < n; k++) begin
      for (int m = 0; m < 3; m++) begin
        case ($urandom_range(0, 3))
          0: a[m] = ANG_W'($urandom_range(0, 65535));
          1: a[m] = ANG_W'($signed($urandom_range(0, 25736)) - 12868);
          2: a[m] = ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) ^ ANG_W'($urandom_range(0, 3));
          default: a[m] = ANG_W'($signed($urandom_range(0, 2000)) - 1000);
        endcase
      end
      send_request(SEL_W'($urandom_range(0, 3)), a[0], a[1], a[2], 0, nil, k > 20);
    end
    release_start();
  endtask

  dir_row_t dir_rows [$];

  initial begin
    pose_t nil, zero_pose;
    dir_row_t row;
    logic signed [ANG_W-1:0] edge_ang [6] = '{16'sh0000, 16'sh7fff, 16'sh8000,
      16'sh3244, -16'sh3244, 16'sh6488};
    link_len = '{6400, 12800, 17920, 12800, 2432};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Finger 2 at zero angles with reset lengths: base angle is +pi/2.
    zero_pose = '{rxx: 0, rxy: -16384, rxz: 0, ryx: 16384, ryy: 0, ryz: 0,
                  rzx: 0, rzz: 16384, px: 0, py: 43520, pz: 2432};
    dir_rows.push_back('{2'd2, 16'sd0, 16'sd0, 16'sd0, 1, zero_pose});
    for (int f = 0; f < 4; f++)
      for (int e = 0; e < 6; e++) begin
        row = '{SEL_W'(f), edge_ang[e], edge_ang[(e + 1) % 6], edge_ang[(e + 3) % 6], 0, nil};
        if (f != 2 || e != 0) dir_rows.push_back(row);
      end
    foreach (dir_rows[i])
      send_request(dir_rows[i].sel, dir_rows[i].spread, dir_rows[i].inner,
                   dir_rows[i].outer, dir_rows[i].has_pose, dir_rows[i].pose, 0);
    release_start();
    drain();

    // Several length settings, extremes included; the unused index must be ignored.
    for (int phase = 0; phase < 4; phase++) begin
      for (int r = 0; r <= REG_TIP_OFFSET; r++)
        write_reg(IDX_W'(r), (phase == 0) ? 16'hffff : (phase == 1) ? 16'h0000 :
                  LEN_W'($urandom_range(0, 65535)));
      write_reg(REG_UNUSED, LEN_W'($urandom_range(0, 65535)));
      random_phase(N_RANDOM / 4);
      drain();
    end

    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
